### sv/zdsvf_pkg.sv
// Shared types, constants and the microcode program of the zero-delay state variable filter.
// Used by zdsvf_div and zero_delay_state_variable_filter; no dependencies.
`default_nettype none

package zdsvf_pkg;

  // Field widths
  localparam int SAMPLE_W = 16;  // Q1.15 sample in/out
  localparam int CUTOFF_W = 18;  // g, unsigned Q2.16
  localparam int DAMP_W   = 17;  // R, unsigned Q1.16
  localparam int G1_W     = DAMP_W + 2;  // 2R + g
  localparam int GAIN_W   = 16;  // mix gains, Q2.14
  localparam int STATE_W  = 32;  // integrators, Q8.24

  localparam int IN_DATA_W  = ((SAMPLE_W + CUTOFF_W + DAMP_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((SAMPLE_W + 7) / 8) * 8;

  // Datapath widths
  localparam int ACC_W   = 64;
  localparam int WIDE_W  = 42;             // hp/bp/lp/v operands
  localparam int CHUNK_W = WIDE_W / 2;     // multiplier operand chunk
  localparam int MULA_W  = 20;
  localparam int MULB_W  = CHUNK_W + 1;
  localparam int PROD_W  = MULA_W + MULB_W;

  // Divider
  localparam int NUM_W       = 52;         // numerator, signed
  localparam int DEN_W       = 30;         // den >> 8
  localparam int DEN_DROP    = 8;
  localparam int DIV_PRESH   = 8;          // numerator scaled by 2^8 before dividing
  localparam int QUO_W       = 36;         // quotient, signed
  localparam int DIVD_W      = NUM_W - 1 + DIV_PRESH;
  localparam int DIV_STEPS   = QUO_W / 2;  // two quotient bits a cycle
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int DEN_MIN_BIT = 24;         // den24 >= 2^24 always

  // Fixed-point shifts
  localparam int X_SHIFT   = 25;
  localparam int S1_SHIFT  = 16;
  localparam int V_SHIFT   = 16;
  localparam int ONE_SHIFT = 32;
  localparam int OUT_SHIFT = 23;

  localparam logic signed [ACC_W-1:0] ACC_ONE   = ACC_W'(1) << ONE_SHIFT;
  localparam logic signed [ACC_W-1:0] ACC_ROUND = ACC_W'(1) << (OUT_SHIFT - 1);

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [STATE_W-1:0]  STATE_MAX  = {1'b0, {(STATE_W-1){1'b1}}};
  localparam logic signed [STATE_W-1:0]  STATE_MIN  = {1'b1, {(STATE_W-1){1'b0}}};

  // Config register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_HP_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BP_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LP_GAIN = 2'd2;

  localparam logic signed [GAIN_W-1:0] HP_GAIN_RST = 16'sd0;
  localparam logic signed [GAIN_W-1:0] BP_GAIN_RST = 16'sd16384;
  localparam logic signed [GAIN_W-1:0] LP_GAIN_RST = 16'sd0;

  // Microcode
  localparam int UC_STEPS = 26;
  localparam int PC_W     = $clog2(UC_STEPS);
  localparam logic [PC_W-1:0] STEP_DIV_WAIT = PC_W'(7);
  localparam logic [PC_W-1:0] STEP_OUT      = PC_W'(25);

  typedef enum logic [2:0] {A_G, A_G1, A_HG, A_BG, A_LG} a_sel_t;
  typedef enum logic [2:0] {B_G1, B_S0, B_HP, B_BP, B_LP} b_sel_t;
  typedef enum logic [2:0] {
    T_PROD, T_X, T_S1SH, T_ONE, T_S0, T_S1, T_V, T_ROUND
  } term_t;
  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_t;
  typedef enum logic [3:0] {
    ACT_NONE, ACT_LD_DEN, ACT_DIV_START, ACT_LD_V, ACT_LD_BP, ACT_LD_LP,
    ACT_SAT_S0, ACT_SAT_S1, ACT_OUT
  } act_t;
  typedef enum logic [1:0] {JMP_NEXT, JMP_DIV, JMP_OUT} jmp_t;

  typedef struct packed {
    a_sel_t          a_sel;
    b_sel_t          b_sel;
    logic            b_hi;     // upper chunk of the wide operand, weight 2^21
    term_t           term;
    acc_op_t         acc_op;
    act_t            act;
    jmp_t            jmp;
    logic [PC_W-1:0] target;
  } ucw_t;

  localparam ucw_t UCW_NOP = '{
    a_sel: A_G, b_sel: B_G1, b_hi: 1'b0, term: T_PROD, acc_op: ACC_HOLD,
    act: ACT_NONE, jmp: JMP_NEXT, target: '0
  };

  // HP = (x - g1*s0 - s1) / (1 + g*g1), then BP, LP, state update and mix.
  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    w = UCW_NOP;
    case (pc)
      // den = 2^32 + g*g1
      PC_W'(0):  begin w.a_sel = A_G; w.b_sel = B_G1; w.acc_op = ACC_LOAD; end
      PC_W'(1):  begin w.term = T_ONE; w.acc_op = ACC_ADD; end
      // num = x*2^25 - g1*s0 - s1*2^16
      PC_W'(2):  begin w.act = ACT_LD_DEN; w.term = T_X; w.acc_op = ACC_LOAD; end
      PC_W'(3):  begin w.a_sel = A_G1; w.b_sel = B_S0; w.acc_op = ACC_SUB; end
      PC_W'(4):  begin
        w.a_sel = A_G1; w.b_sel = B_S0; w.b_hi = 1'b1; w.acc_op = ACC_SUB;
      end
      PC_W'(5):  begin w.term = T_S1SH; w.acc_op = ACC_SUB; end
      PC_W'(6):  begin w.act = ACT_DIV_START; end
      PC_W'(7):  begin w.jmp = JMP_DIV; w.target = STEP_DIV_WAIT; end
      // v1 = g*hp >> 16; bp = v1 + s0; s0 <= sat(bp + v1)
      PC_W'(8):  begin w.a_sel = A_G; w.b_sel = B_HP; w.acc_op = ACC_LOAD; end
      PC_W'(9):  begin
        w.a_sel = A_G; w.b_sel = B_HP; w.b_hi = 1'b1; w.acc_op = ACC_ADD;
      end
      PC_W'(10): begin w.act = ACT_LD_V; w.term = T_S0; w.acc_op = ACC_LOAD; end
      PC_W'(11): begin w.term = T_V; w.acc_op = ACC_ADD; end
      PC_W'(12): begin w.act = ACT_LD_BP; w.term = T_V; w.acc_op = ACC_ADD; end
      // v2 = g*bp >> 16; lp = v2 + s1; s1 <= sat(lp + v2)
      PC_W'(13): begin
        w.act = ACT_SAT_S0; w.a_sel = A_G; w.b_sel = B_BP; w.acc_op = ACC_LOAD;
      end
      PC_W'(14): begin
        w.a_sel = A_G; w.b_sel = B_BP; w.b_hi = 1'b1; w.acc_op = ACC_ADD;
      end
      PC_W'(15): begin w.act = ACT_LD_V; w.term = T_S1; w.acc_op = ACC_LOAD; end
      PC_W'(16): begin w.term = T_V; w.acc_op = ACC_ADD; end
      PC_W'(17): begin w.act = ACT_LD_LP; w.term = T_V; w.acc_op = ACC_ADD; end
      // mix
      PC_W'(18): begin
        w.act = ACT_SAT_S1; w.a_sel = A_HG; w.b_sel = B_HP; w.acc_op = ACC_LOAD;
      end
      PC_W'(19): begin
        w.a_sel = A_HG; w.b_sel = B_HP; w.b_hi = 1'b1; w.acc_op = ACC_ADD;
      end
      PC_W'(20): begin w.a_sel = A_BG; w.b_sel = B_BP; w.acc_op = ACC_ADD; end
      PC_W'(21): begin
        w.a_sel = A_BG; w.b_sel = B_BP; w.b_hi = 1'b1; w.acc_op = ACC_ADD;
      end
      PC_W'(22): begin w.a_sel = A_LG; w.b_sel = B_LP; w.acc_op = ACC_ADD; end
      PC_W'(23): begin
        w.a_sel = A_LG; w.b_sel = B_LP; w.b_hi = 1'b1; w.acc_op = ACC_ADD;
      end
      PC_W'(24): begin w.term = T_ROUND; w.acc_op = ACC_ADD; end
      PC_W'(25): begin w.act = ACT_OUT; w.jmp = JMP_OUT; w.target = STEP_OUT; end
      default:   begin w.jmp = JMP_OUT; w.target = STEP_OUT; end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### sv/zdsvf_div.sv
// Radix-4 restoring divider: signed numerator scaled by 2^8 over positive divisor,
// quotient truncated toward zero. Depends on zdsvf_pkg.
`default_nettype none

module zdsvf_div (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic signed [zdsvf_pkg::NUM_W-1:0]  num,
  input  wire logic        [zdsvf_pkg::DEN_W-1:0]  den,
  output logic                                     busy,
  output logic signed      [zdsvf_pkg::QUO_W-1:0]  quot
);

  logic                              busy_r, busy_nxt;
  logic [zdsvf_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [zdsvf_pkg::DEN_W-1:0]       den_r, den_nxt;
  logic [zdsvf_pkg::DEN_W-1:0]       rem_r, rem_nxt;
  logic [zdsvf_pkg::QUO_W-1:0]       qd_r, qd_nxt;
  logic                              neg_r, neg_nxt;

  logic [zdsvf_pkg::NUM_W-1:0]       mag;
  logic [zdsvf_pkg::DIVD_W-1:0]      dvd;
  logic [zdsvf_pkg::DEN_W:0]         t1, t2;
  logic [zdsvf_pkg::DEN_W-1:0]       r1, r2;
  logic                              q1, q2;

  always_comb begin
    mag = num[zdsvf_pkg::NUM_W-1] ? -num : num;
    dvd = {mag[zdsvf_pkg::NUM_W-2:0], {zdsvf_pkg::DIV_PRESH{1'b0}}};

    // two restoring steps per cycle; remainder always below den_r
    t1 = {rem_r, qd_r[zdsvf_pkg::QUO_W-1]};
    q1 = (t1 >= {1'b0, den_r});
    r1 = q1 ? zdsvf_pkg::DEN_W'(t1 - {1'b0, den_r}) : t1[zdsvf_pkg::DEN_W-1:0];
    t2 = {r1, qd_r[zdsvf_pkg::QUO_W-2]};
    q2 = (t2 >= {1'b0, den_r});
    r2 = q2 ? zdsvf_pkg::DEN_W'(t2 - {1'b0, den_r}) : t2[zdsvf_pkg::DEN_W-1:0];

    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    qd_nxt   = qd_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      den_nxt  = den;
      neg_nxt  = num[zdsvf_pkg::NUM_W-1];
      rem_nxt  = zdsvf_pkg::DEN_W'(dvd[zdsvf_pkg::DIVD_W-1:zdsvf_pkg::QUO_W]);
      qd_nxt   = dvd[zdsvf_pkg::QUO_W-1:0];
    end else if (busy_r) begin
      rem_nxt = r2;
      qd_nxt  = {qd_r[zdsvf_pkg::QUO_W-3:0], q1, q2};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == zdsvf_pkg::DIV_CNT_W'(zdsvf_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    qd_r  <= qd_nxt;
    neg_r <= neg_nxt;
  end

  assign busy = busy_r;
  assign quot = neg_r ? -$signed(qd_r) : $signed(qd_r);

endmodule

`default_nettype wire

### sv/zero_delay_state_variable_filter.sv
// Top level of the zero-delay (trapezoidal) state variable filter: stream ports,
// microcoded MAC datapath and state. Depends on zdsvf_pkg and zdsvf_div.
`default_nettype none

// The result is presented when the program finishes after the input beat is accepted;
// the next beat can be taken in the same cycle. 26 microcode steps run a single 20x22
// multiply-accumulate unit (wide operands in two chunks); the sequencer waits at one
// step while the divider runs, which retires two quotient bits a cycle. A finished result
// sits in the output register while the next sample is accepted; the sequencer only
// waits at its last step if that register is still full. The gains are read during the
// mix steps of a running sample, so write them only while no sample is in flight.
module zero_delay_state_variable_filter (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     in_tvalid,
  output logic                                          in_tready,
  // [15:0] sample_in, [33:16] cutoff_gain, [50:34] damping, [55:51] zero
  input  wire logic [zdsvf_pkg::IN_DATA_W-1:0]          in_tdata,
  output logic                                          out_tvalid,
  input  wire logic                                     out_tready,
  // [15:0] sample_out
  output logic [zdsvf_pkg::OUT_DATA_W-1:0]              out_tdata,
  // [0] clipped
  output logic                                          out_tuser,
  input  wire logic                                     cfg_valid,
  output logic                                          cfg_ready,
  input  wire logic [zdsvf_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [zdsvf_pkg::GAIN_W-1:0]             cfg_data
);

  localparam int SW  = zdsvf_pkg::SAMPLE_W;
  localparam int CW  = zdsvf_pkg::CUTOFF_W;
  localparam int DW  = zdsvf_pkg::DAMP_W;
  localparam int AW  = zdsvf_pkg::ACC_W;
  localparam int WW  = zdsvf_pkg::WIDE_W;
  localparam int PW  = zdsvf_pkg::PROD_W;
  localparam int STW = zdsvf_pkg::STATE_W;
  localparam int GNW = zdsvf_pkg::GAIN_W;

  // control
  logic                          busy_r, busy_nxt;
  logic [zdsvf_pkg::PC_W-1:0]    pc_r, pc_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [GNW-1:0]         hg_r, bg_r, lg_r;
  logic signed [STW-1:0]         s0_r, s0_nxt, s1_r, s1_nxt;

  // payload
  logic signed [SW-1:0]          x_r, x_nxt;
  logic [CW-1:0]                 g_r, g_nxt;
  logic [zdsvf_pkg::G1_W-1:0]    g1_r, g1_nxt;
  logic signed [AW-1:0]          acc_r, acc_nxt;
  logic [zdsvf_pkg::DEN_W-1:0]   den_r, den_nxt;
  logic signed [WW-1:0]          v_r, v_nxt, bp_r, bp_nxt, lp_r, lp_nxt;
  logic                          clip_r, clip_nxt;
  logic [SW-1:0]                 out_data_r, out_data_nxt;
  logic                          out_clip_r, out_clip_nxt;

  zdsvf_pkg::ucw_t               uw;
  logic                          in_accept, out_free;
  logic                          div_start, div_busy;
  logic signed [zdsvf_pkg::QUO_W-1:0] hp;

  logic signed [zdsvf_pkg::MULA_W-1:0] mul_a;
  logic signed [WW-1:0]          b_wide;
  logic signed [zdsvf_pkg::MULB_W-1:0] mul_b;
  logic signed [PW-1:0]          prod;
  logic signed [AW-1:0]          prod_ext, term;
  logic                          st_ovf, out_ovf;
  logic signed [STW-1:0]         st_sat;
  logic [SW-1:0]                 y_sat;

  assign uw         = zdsvf_pkg::ucode(pc_r);
  assign in_tready  = !busy_r;
  assign in_accept  = in_tvalid && !busy_r;
  assign out_free   = !out_valid_r || out_tready;
  assign cfg_ready  = 1'b1;
  assign div_start  = busy_r && (uw.act == zdsvf_pkg::ACT_DIV_START);

  zdsvf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (acc_r[zdsvf_pkg::NUM_W-1:0]),
    .den   (den_r),
    .busy  (div_busy),
    .quot  (hp)
  );

  // multiplier operands
  always_comb begin
    case (uw.a_sel)
      zdsvf_pkg::A_G:  mul_a = $signed({2'b00, g_r});
      zdsvf_pkg::A_G1: mul_a = $signed({1'b0, g1_r});
      zdsvf_pkg::A_HG: mul_a = {{(zdsvf_pkg::MULA_W-GNW){hg_r[GNW-1]}}, hg_r};
      zdsvf_pkg::A_BG: mul_a = {{(zdsvf_pkg::MULA_W-GNW){bg_r[GNW-1]}}, bg_r};
      zdsvf_pkg::A_LG: mul_a = {{(zdsvf_pkg::MULA_W-GNW){lg_r[GNW-1]}}, lg_r};
      default:         mul_a = '0;
    endcase
    case (uw.b_sel)
      zdsvf_pkg::B_G1: b_wide = $signed({{(WW-zdsvf_pkg::G1_W){1'b0}}, g1_r});
      zdsvf_pkg::B_S0: b_wide = {{(WW-STW){s0_r[STW-1]}}, s0_r};
      zdsvf_pkg::B_HP: b_wide = {{(WW-zdsvf_pkg::QUO_W){hp[zdsvf_pkg::QUO_W-1]}}, hp};
      zdsvf_pkg::B_BP: b_wide = bp_r;
      zdsvf_pkg::B_LP: b_wide = lp_r;
      default:         b_wide = '0;
    endcase
    // wide operand = hi * 2^21 + lo, lo unsigned
    mul_b = uw.b_hi ? {b_wide[WW-1], b_wide[WW-1:zdsvf_pkg::CHUNK_W]}
                    : {1'b0, b_wide[zdsvf_pkg::CHUNK_W-1:0]};
    prod     = mul_a * mul_b;
    prod_ext = {{(AW-PW){prod[PW-1]}}, prod};
  end

  always_comb begin
    case (uw.term)
      zdsvf_pkg::T_PROD:  term = uw.b_hi ? (prod_ext <<< zdsvf_pkg::CHUNK_W) : prod_ext;
      zdsvf_pkg::T_X:     term = {{(AW-SW-zdsvf_pkg::X_SHIFT){x_r[SW-1]}}, x_r,
                                  {zdsvf_pkg::X_SHIFT{1'b0}}};
      zdsvf_pkg::T_S1SH:  term = {{(AW-STW-zdsvf_pkg::S1_SHIFT){s1_r[STW-1]}}, s1_r,
                                  {zdsvf_pkg::S1_SHIFT{1'b0}}};
      zdsvf_pkg::T_ONE:   term = zdsvf_pkg::ACC_ONE;
      zdsvf_pkg::T_S0:    term = {{(AW-STW){s0_r[STW-1]}}, s0_r};
      zdsvf_pkg::T_S1:    term = {{(AW-STW){s1_r[STW-1]}}, s1_r};
      zdsvf_pkg::T_V:     term = {{(AW-WW){v_r[WW-1]}}, v_r};
      zdsvf_pkg::T_ROUND: term = zdsvf_pkg::ACC_ROUND;
      default:            term = '0;
    endcase
  end

  // saturation of the accumulator to a state and to the output sample
  always_comb begin
    st_ovf  = !((&acc_r[AW-1:STW-1]) || !(|acc_r[AW-1:STW-1]));
    st_sat  = st_ovf ? (acc_r[AW-1] ? zdsvf_pkg::STATE_MIN : zdsvf_pkg::STATE_MAX)
                     : acc_r[STW-1:0];
    out_ovf = !((&acc_r[AW-1:zdsvf_pkg::OUT_SHIFT+SW-1]) ||
                !(|acc_r[AW-1:zdsvf_pkg::OUT_SHIFT+SW-1]));
    y_sat   = out_ovf ? (acc_r[AW-1] ? zdsvf_pkg::SAMPLE_MIN : zdsvf_pkg::SAMPLE_MAX)
                      : acc_r[zdsvf_pkg::OUT_SHIFT+SW-1:zdsvf_pkg::OUT_SHIFT];
  end

  // sequencer and datapath next state
  always_comb begin
    busy_nxt      = busy_r;
    pc_nxt        = pc_r;
    out_valid_nxt = out_valid_r;
    s0_nxt        = s0_r;
    s1_nxt        = s1_r;
    x_nxt         = x_r;
    g_nxt         = g_r;
    g1_nxt        = g1_r;
    acc_nxt       = acc_r;
    den_nxt       = den_r;
    v_nxt         = v_r;
    bp_nxt        = bp_r;
    lp_nxt        = lp_r;
    clip_nxt      = clip_r;
    out_data_nxt  = out_data_r;
    out_clip_nxt  = out_clip_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_accept) begin
      x_nxt    = in_tdata[SW-1:0];
      g_nxt    = in_tdata[SW+CW-1:SW];
      g1_nxt   = {in_tdata[SW+CW+DW-1:SW+CW], 1'b0} + {1'b0, in_tdata[SW+CW-1:SW]};
      clip_nxt = 1'b0;
      busy_nxt = 1'b1;
      pc_nxt   = '0;
    end else if (busy_r) begin
      case (uw.acc_op)
        zdsvf_pkg::ACC_HOLD: acc_nxt = acc_r;
        zdsvf_pkg::ACC_LOAD: acc_nxt = term;
        zdsvf_pkg::ACC_ADD:  acc_nxt = acc_r + term;
        zdsvf_pkg::ACC_SUB:  acc_nxt = acc_r - term;
        default:             acc_nxt = acc_r;
      endcase

      case (uw.act)
        zdsvf_pkg::ACT_NONE:      ;
        zdsvf_pkg::ACT_DIV_START: ;
        zdsvf_pkg::ACT_LD_DEN:
          den_nxt = acc_r[zdsvf_pkg::DEN_W+zdsvf_pkg::DEN_DROP-1:zdsvf_pkg::DEN_DROP];
        zdsvf_pkg::ACT_LD_V:      v_nxt  = acc_r[WW+zdsvf_pkg::V_SHIFT-1:zdsvf_pkg::V_SHIFT];
        zdsvf_pkg::ACT_LD_BP:     bp_nxt = acc_r[WW-1:0];
        zdsvf_pkg::ACT_LD_LP:     lp_nxt = acc_r[WW-1:0];
        zdsvf_pkg::ACT_SAT_S0: begin
          s0_nxt   = st_sat;
          clip_nxt = clip_r || st_ovf;
        end
        zdsvf_pkg::ACT_SAT_S1: begin
          s1_nxt   = st_sat;
          clip_nxt = clip_r || st_ovf;
        end
        zdsvf_pkg::ACT_OUT: begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = y_sat;
            out_clip_nxt  = clip_r || out_ovf;
          end
        end
        default: ;
      endcase

      case (uw.jmp)
        zdsvf_pkg::JMP_NEXT: pc_nxt = pc_r + 1'b1;
        zdsvf_pkg::JMP_DIV:  pc_nxt = div_busy ? uw.target : pc_r + 1'b1;
        zdsvf_pkg::JMP_OUT: begin
          if (out_free) begin
            pc_nxt   = '0;
            busy_nxt = 1'b0;
          end else begin
            pc_nxt = uw.target;
          end
        end
        default: begin
          pc_nxt   = '0;
          busy_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
      s0_r        <= '0;
      s1_r        <= '0;
      hg_r        <= zdsvf_pkg::HP_GAIN_RST;
      bg_r        <= zdsvf_pkg::BP_GAIN_RST;
      lg_r        <= zdsvf_pkg::LP_GAIN_RST;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      s0_r        <= s0_nxt;
      s1_r        <= s1_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          zdsvf_pkg::REG_HP_GAIN: hg_r <= cfg_data;
          zdsvf_pkg::REG_BP_GAIN: bg_r <= cfg_data;
          zdsvf_pkg::REG_LP_GAIN: lg_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    g_r        <= g_nxt;
    g1_r       <= g1_nxt;
    acc_r      <= acc_nxt;
    den_r      <= den_nxt;
    v_r        <= v_nxt;
    bp_r       <= bp_nxt;
    lp_r       <= lp_nxt;
    clip_r     <= clip_nxt;
    out_data_r <= out_data_nxt;
    out_clip_r <= out_clip_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_clip_r;

  // an accepted beat starts the program at step zero
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> busy_r && (pc_r == '0))
    else $error("sequencer did not start on accepted beat");

  // sequencer rests at step zero when idle
  a_idle_pc: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (pc_r == '0))
    else $error("step counter moved while idle");

  // divider launched only when free and with a divisor of at least 2^24
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy && (den_r[zdsvf_pkg::DEN_W-1:zdsvf_pkg::DEN_MIN_BIT] != '0))
    else $error("bad divider launch");

  // a result appears only from the output step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(busy_r && (pc_r == zdsvf_pkg::STEP_OUT)))
    else $error("result loaded outside output step");

endmodule

`default_nettype wire
